// File: hw/rtl/sxyy_pkg.sv
`timescale 1ns / 1ps

package sxyy_pkg;

    // Fraction bits of every Q.F quantity in the datapath
    localparam int FRAC_BITS = 16;

    // Lanes: one per colour channel on the way in; x and y go through the divider
    localparam int NLANES   = 3;
    localparam int NDIV     = 2;
    localparam int LANE_X   = 0;
    localparam int LANE_Y   = 1;

    // Widths
    localparam int CH_W    = 8;                  // gamma-encoded channel byte
    localparam int LIN_W   = FRAC_BITS + 1;      // linear value, 1.0 inclusive
    localparam int COEF_W  = 14;                 // matrix coefficients, scaled by 10000
    localparam int PROD_W  = LIN_W + COEF_W;     // one coefficient product
    localparam int SUM_W   = FRAC_BITS + 14;     // X, Y or Z sum (row sums below 2^14)
    localparam int SS_W    = FRAC_BITS + 15;     // X+Y+Z (sum of all coefficients below 2^15)
    localparam int QW      = FRAC_BITS + 1;      // quotient / result field width
    localparam int NUM_W   = SUM_W + FRAC_BITS + 1;
    localparam int DIV_W   = SS_W;

    localparam int IN_TDATA_W  = NLANES * CH_W;
    localparam int OUT_TDATA_W = ((NLANES * QW + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - NLANES * QW;

    // Luminance is (Y + 5000) / 10000, done as a multiply by the rounded-up
    // reciprocal; exact because Y + 5000 stays below 2^SUM_W
    localparam int LUM_MUL_W  = SUM_W + 1;
    localparam int LUM_SHIFT  = SUM_W + 14;
    localparam int LUM_PROD_W = SUM_W + LUM_MUL_W;
    localparam logic [LUM_MUL_W-1:0] LUM_MUL =
        LUM_MUL_W'(((64'd1 << LUM_SHIFT) + 64'd9999) / 64'd10000);
    localparam logic [SUM_W-1:0] LUM_RND = SUM_W'(5000);

    // sRGB to XYZ matrix, rows X/Y/Z, columns R/G/B, scaled by 10000
    typedef logic [COEF_W-1:0] t_coef;
    localparam t_coef COEF [NLANES][NLANES] = '{
        '{14'd4124, 14'd3576, 14'd1805},
        '{14'd2126, 14'd7152, 14'd722},
        '{14'd193,  14'd1192, 14'd9505}
    };

    typedef logic [NLANES-1:0][CH_W-1:0]  t_rgb;
    typedef logic [NLANES-1:0][LIN_W-1:0] t_lin_vec;
    typedef logic [255:0][LIN_W-1:0]      t_lin_lut;

    // Operands handed from the matrix to the divider
    typedef struct packed {
        logic [NDIV-1:0][NUM_W-1:0] num;
        logic [NDIV-1:0][DIV_W-1:0] dvs;
        logic [QW-1:0]              lum;
        logic                       black;
    } t_div_in;

    // Quotients leaving the divider
    typedef struct packed {
        logic [NDIV-1:0][QW-1:0] quot;
        logic [QW-1:0]           lum;
        logic                    black;
    } t_div_out;

    // Q0.30 multiply, rounded to nearest
    function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [63:0] q30_pow5(input logic [63:0] r);
        logic [63:0] p;
        p = r;
        for (int i = 0; i < 4; i++) begin
            p = q30_mul(p, r);
        end
        return p;
    endfunction

    // Inverse sRGB gamma, evaluated once at elaboration into a constant table
    function automatic t_lin_lut build_lin_lut();
        t_lin_lut    lut;
        logic [63:0] c;
        logic [63:0] t;
        logic [63:0] sq;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] val;
        for (int i = 0; i < 256; i++) begin
            c = 64'(i);
            if (c <= 64'd10) begin
                val = (((c * 64'd10) << FRAC_BITS) + 64'd16473) / 64'd32946;
            end else begin
                t  = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
                sq = q30_mul(t, t);
                // fifth root of t^2 by bisection
                lo = 64'd0;
                hi = 64'd1 << 30;
                while (lo < hi) begin
                    mid = lo + ((hi - lo + 64'd1) >> 1);
                    if (q30_pow5(mid) <= sq) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
                val = (sq * lo + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
            end
            lut[i] = val[LIN_W-1:0];
        end
        return lut;
    endfunction

    localparam t_lin_lut LIN_LUT = build_lin_lut();

endpackage

// File: hw/rtl/srgb_to_cie_xyy.sv
`timescale 1ns / 1ps

// sRGB to CIE xyY colour converter.
// Slave channel: one transaction per pixel, tdata = red [7:0], green [15:8], blue [23:16].
// Master channel: one transaction per pixel, tdata = chroma_x [16:0], chroma_y [33:17],
// luminance [50:34], upper bits zero. All results unsigned Q.16; x and y are zero for black.
// Pipeline: FRAC_BITS + 5 register stages (21): the gamma table lookup, the matrix
// stages (products, row sums, operands and luminance), then one restoring-division
// stage per quotient bit for x and y, with luminance carried alongside.
// Throughput: one pixel per clock unless stalled; every stage holds a valid bit and advances
// whenever it is empty or the stage after it moves, so bubbles are squeezed out.
// When the receiver stalls, the pipeline keeps filling until every stage holds
// a pixel; only then does o_s_axis_tready drop. Nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; the block has no other
// state and is ready for input in the cycle after reset is released.
module srgb_to_cie_xyy (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [sxyy_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // chroma_x [16:0], chroma_y [33:17], luminance [50:34], zero padding above
    output logic [sxyy_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);
    import sxyy_pkg::*;

    t_rgb     w_rgb;
    t_lin_vec w_lin;
    logic     w_lin_valid;
    logic     w_lin_ready;
    t_div_in  w_div;
    logic     w_div_valid;
    logic     w_div_ready;
    t_div_out w_quot;
    logic [QW-1:0] w_cx;
    logic [QW-1:0] w_cy;
    logic [QW-1:0] w_lum;

    assign w_rgb = i_s_axis_tdata;

    sxyy_linearize u_linearize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_rgb   (w_rgb),
        .o_valid (w_lin_valid),
        .i_ready (w_lin_ready),
        .o_lin   (w_lin)
    );

    sxyy_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_lin_valid),
        .o_ready (w_lin_ready),
        .i_lin   (w_lin),
        .o_valid (w_div_valid),
        .i_ready (w_div_ready),
        .o_div   (w_div)
    );

    sxyy_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .o_ready (w_div_ready),
        .i_div   (w_div),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_quot  (w_quot)
    );

    // black has no chromaticity: force x and y to zero
    assign w_cx  = w_quot.black ? '0 : w_quot.quot[LANE_X];
    assign w_cy  = w_quot.black ? '0 : w_quot.quot[LANE_Y];
    assign w_lum = w_quot.lum;

    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_lum, w_cy, w_cx};

    // input can only be refused when the whole pipeline is full and stalled
    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input refused while pipeline not stalled");

    // x + y cannot exceed one (plus rounding)
    a_xy_sum : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((QW+1)'(w_cx) + (QW+1)'(w_cy) <= (QW+1)'((1 << FRAC_BITS) + 1)))
        else $error("chromaticity sum above one");

    // luminance never above white
    a_lum_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_lum <= QW'(1 << FRAC_BITS)))
        else $error("luminance above white");

endmodule

// File: hw/rtl/sxyy_linearize.sv
`timescale 1ns / 1ps

module sxyy_linearize (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sxyy_pkg::t_rgb      i_rgb,
    output logic                o_valid,
    input  logic                i_ready,
    output sxyy_pkg::t_lin_vec  o_lin
);
    import sxyy_pkg::*;

    logic     r_valid;
    t_lin_vec r_lin;
    t_lin_vec n_lin;
    logic     w_en;

    // stage advances when empty or when downstream takes its transaction
    assign w_en    = ~r_valid | i_ready;
    assign o_ready = w_en;

    // table lookup, one per channel
    always_comb begin
        for (int k = 0; k < NLANES; k++) begin
            n_lin[k] = LIN_LUT[i_rgb[k]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lin <= n_lin;
        end
    end

    assign o_valid = r_valid;
    assign o_lin   = r_lin;

endmodule

// File: hw/rtl/sxyy_matrix.sv
`timescale 1ns / 1ps

module sxyy_matrix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sxyy_pkg::t_lin_vec  i_lin,
    output logic                o_valid,
    input  logic                i_ready,
    output sxyy_pkg::t_div_in   o_div
);
    import sxyy_pkg::*;

    // three stages: products, row sums, divider operands
    logic [2:0]            r_valid;
    logic [3:0]            w_en;
    logic [PROD_W-1:0]     r_prod [NLANES][NLANES];
    logic [SUM_W-1:0]      r_sum  [NLANES];
    logic [SUM_W-1:0]      r_ylum;
    t_div_in               r_div;
    logic [SUM_W-1:0]      n_sum  [NLANES];
    logic [SUM_W-1:0]      n_ylum;
    t_div_in               n_div;
    logic [PROD_W+1:0]     w_row  [NLANES];
    logic [SS_W-1:0]       w_ss;
    logic [LUM_PROD_W-1:0] w_lum_prod;

    // ready ripples back through empty stages
    always_comb begin
        w_en[3] = i_ready;
        for (int s = 2; s >= 0; s--) begin
            w_en[s] = ~r_valid[s] | w_en[s+1];
        end
    end
    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) r_valid[0] <= i_valid;
            if (w_en[1]) r_valid[1] <= r_valid[0];
            if (w_en[2]) r_valid[2] <= r_valid[1];
        end
    end

    // stage 1: coefficient products
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int row = 0; row < NLANES; row++) begin
                for (int col = 0; col < NLANES; col++) begin
                    r_prod[row][col] <= PROD_W'(i_lin[col]) * PROD_W'(COEF[row][col]);
                end
            end
        end
    end

    // stage 2: row sums X, Y, Z (scaled by 10000), Y with its rounding offset
    always_comb begin
        for (int row = 0; row < NLANES; row++) begin
            w_row[row] = (PROD_W+2)'(r_prod[row][0]) + (PROD_W+2)'(r_prod[row][1])
                       + (PROD_W+2)'(r_prod[row][2]);
            n_sum[row] = w_row[row][SUM_W-1:0];
        end
        n_ylum = n_sum[1] + LUM_RND;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_sum  <= n_sum;
            r_ylum <= n_ylum;
        end
    end

    // stage 3: total, rounded numerators for the divider lanes, luminance
    always_comb begin
        w_ss = SS_W'(r_sum[0]) + SS_W'(r_sum[1]) + SS_W'(r_sum[2]);
        n_div.num[LANE_X] = {r_sum[0], {FRAC_BITS{1'b0}}} + NUM_W'(w_ss >> 1);
        n_div.num[LANE_Y] = {r_sum[1], {FRAC_BITS{1'b0}}} + NUM_W'(w_ss >> 1);
        n_div.dvs[LANE_X] = w_ss;
        n_div.dvs[LANE_Y] = w_ss;
        w_lum_prod        = LUM_PROD_W'(r_ylum) * LUM_PROD_W'(LUM_MUL);
        n_div.lum         = w_lum_prod[LUM_SHIFT +: QW];
        n_div.black       = (w_ss == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid[2];
    assign o_div   = r_div;

endmodule

// File: hw/rtl/sxyy_divider.sv
`timescale 1ns / 1ps

module sxyy_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sxyy_pkg::t_div_in   i_div,
    output logic                o_valid,
    input  logic                i_ready,
    output sxyy_pkg::t_div_out  o_quot
);
    import sxyy_pkg::*;

    // restoring division, one quotient bit per stage, x and y lanes side by side;
    // luminance is already final and travels alongside
    logic [QW-1:0]    r_valid;
    logic [QW:0]      w_en;
    logic [DIV_W-1:0] r_rem   [QW][NDIV];
    logic [DIV_W-1:0] r_dvs   [QW][NDIV];
    logic [QW-1:0]    r_qn    [QW][NDIV];  // remaining numerator bits, quotient shifts in
    logic [QW-1:0]    r_lum   [QW];
    logic [QW-1:0]    r_black;

    assign w_en[QW] = i_ready;
    assign o_ready  = w_en[0];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic             w_pblack;
        logic             w_pvalid;
        logic [QW-1:0]    w_plum;
        logic [DIV_W-1:0] w_prem [NDIV];
        logic [DIV_W-1:0] w_pdvs [NDIV];
        logic [QW-1:0]    w_pqn  [NDIV];

        // stage input: module operands or the previous stage
        if (s == 0) begin : g_first
            assign w_pvalid = i_valid;
            assign w_pblack = i_div.black;
            assign w_plum   = i_div.lum;
            for (genvar l = 0; l < NDIV; l++) begin : g_lane
                assign w_prem[l] = {{(DIV_W-NUM_W+QW){1'b0}}, i_div.num[l][NUM_W-1:QW]};
                assign w_pdvs[l] = i_div.dvs[l];
                assign w_pqn[l]  = i_div.num[l][QW-1:0];
            end
        end else begin : g_next
            assign w_pvalid = r_valid[s-1];
            assign w_pblack = r_black[s-1];
            assign w_plum   = r_lum[s-1];
            for (genvar l = 0; l < NDIV; l++) begin : g_lane
                assign w_prem[l] = r_rem[s-1][l];
                assign w_pdvs[l] = r_dvs[s-1][l];
                assign w_pqn[l]  = r_qn[s-1][l];
            end
        end

        assign w_en[s] = ~r_valid[s] | w_en[s+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (w_en[s]) begin
                r_valid[s] <= w_pvalid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[s]) begin
                r_black[s] <= w_pblack;
                r_lum[s]   <= w_plum;
            end
        end

        for (genvar l = 0; l < NDIV; l++) begin : g_lane_step
            logic [DIV_W:0]   w_sh;
            logic [DIV_W:0]   w_diff;
            logic             w_ge;
            logic [DIV_W-1:0] n_rem;
            logic [QW-1:0]    n_qn;

            // shift in next numerator bit, subtract if it fits
            always_comb begin
                w_sh   = {w_prem[l], w_pqn[l][QW-1]};
                w_diff = w_sh - {1'b0, w_pdvs[l]};
                w_ge   = (w_sh >= {1'b0, w_pdvs[l]});
                n_rem  = w_ge ? w_diff[DIV_W-1:0] : w_sh[DIV_W-1:0];
                n_qn   = {w_pqn[l][QW-2:0], w_ge};
            end

            always_ff @(posedge i_clk) begin
                if (w_en[s]) begin
                    r_rem[s][l] <= n_rem;
                    r_dvs[s][l] <= w_pdvs[l];
                    r_qn[s][l]  <= n_qn;
                end
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    always_comb begin
        o_quot.black = r_black[QW-1];
        o_quot.lum   = r_lum[QW-1];
        for (int l = 0; l < NDIV; l++) begin
            o_quot.quot[l] = r_qn[QW-1][l];
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import sxyy_pkg::*;

    localparam int NUM_RANDOM  = 1700;
    localparam int TAIL_CYCLES = 40;       // more than the pipeline depth
    localparam int TIMEOUT_NS  = 5_000_000;
    localparam int HOLD_CYCLES = 200;      // long receiver hold-off

    typedef struct packed {
        logic [QW-1:0] luminance;
        logic [QW-1:0] chroma_y;
        logic [QW-1:0] chroma_x;
    } t_xyy;

    // Expected xyY results, in order of acceptance
    class xyy_scoreboard;
        logic [LIN_W-1:0] lin_table [256];
        t_xyy             pending_xyy [$];
        int               error_count;
        int               checked_count;

        // Q0.30 product, rounded to nearest
        function logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
            return (a * b + (64'd1 << 29)) >> 30;
        endfunction

        // Inverse sRGB gamma of one byte, in Q1.FRAC_BITS
        function logic [63:0] gamma_expand(input int unsigned code);
            logic [63:0] c, t, t_sq, lo, hi, mid, pw;
            c = 64'(code);
            if (c <= 64'd10) begin
                return (((c * 64'd10) << FRAC_BITS) + 64'd16473) / 64'd32946;
            end
            t    = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
            t_sq = mul_q30(t, t);
            // largest root whose fifth power does not exceed t^2
            lo = 64'd0;
            hi = 64'd1 << 30;
            while (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                pw  = mid;
                for (int k = 0; k < 4; k++) begin
                    pw = mul_q30(pw, mid);
                end
                if (pw <= t_sq) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
            return (t_sq * lo + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
        endfunction

        function new();
            logic [63:0] v;
            error_count   = 0;
            checked_count = 0;
            for (int i = 0; i < 256; i++) begin
                v            = gamma_expand(i);
                lin_table[i] = v[LIN_W-1:0];
            end
        endfunction

        // Accepted input transaction: work out its xyY
        function void note_pixel(input logic [7:0] red, input logic [7:0] green,
                                 input logic [7:0] blue);
            logic [63:0] lr, lg, lb, xs, ys, zs, ss, cx, cy, lum;
            t_xyy        res;
            lr  = 64'(lin_table[red]);
            lg  = 64'(lin_table[green]);
            lb  = 64'(lin_table[blue]);
            // matrix scaled by 10000
            xs  = 64'd4124 * lr + 64'd3576 * lg + 64'd1805 * lb;
            ys  = 64'd2126 * lr + 64'd7152 * lg + 64'd722  * lb;
            zs  = 64'd193  * lr + 64'd1192 * lg + 64'd9505 * lb;
            ss  = xs + ys + zs;
            cx  = 64'd0;
            cy  = 64'd0;
            if (ss != 64'd0) begin
                cx = ((xs << FRAC_BITS) + (ss >> 1)) / ss;
                cy = ((ys << FRAC_BITS) + (ss >> 1)) / ss;
            end
            lum = (ys + 64'd5000) / 64'd10000;
            res.chroma_x  = cx[QW-1:0];
            res.chroma_y  = cy[QW-1:0];
            res.luminance = lum[QW-1:0];
            pending_xyy.push_back(res);
        endfunction

        // Accepted output transaction: compare with the oldest expectation
        function void check_result(input logic [OUT_TDATA_W-1:0] tdata);
            t_xyy exp_xyy, got;
            got = tdata[NLANES*QW-1:0];
            checked_count++;
            if (pending_xyy.size() == 0) begin
                $error("result with no pixel pending: tdata %h", tdata);
                error_count++;
                return;
            end
            exp_xyy = pending_xyy.pop_front();
            if (got.chroma_x !== exp_xyy.chroma_x) begin
                $error("chroma_x expected %0d got %0d", exp_xyy.chroma_x, got.chroma_x);
                error_count++;
            end
            if (got.chroma_y !== exp_xyy.chroma_y) begin
                $error("chroma_y expected %0d got %0d", exp_xyy.chroma_y, got.chroma_y);
                error_count++;
            end
            if (got.luminance !== exp_xyy.luminance) begin
                $error("luminance expected %0d got %0d", exp_xyy.luminance, got.luminance);
                error_count++;
            end
            if (tdata[OUT_TDATA_W-1:NLANES*QW] !== '0) begin
                $error("padding expected 0 got %h", tdata[OUT_TDATA_W-1:NLANES*QW]);
                error_count++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;   // red, green, blue from bit 0 up
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;         // chroma_x, chroma_y, luminance, pad

    xyy_scoreboard sb;

    srgb_to_cie_xyy dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Offer one pixel and hold it until the block takes it
    task automatic offer_pixel(input logic [7:0] red, input logic [7:0] green,
                               input logic [7:0] blue);
        i_s_axis_tdata  <= {blue, green, red};
        i_s_axis_tvalid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        sb.note_pixel(red, green, blue);
    endtask

    // Channel byte weighted towards the segment boundary and the extremes
    function automatic logic [7:0] pick_channel();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            return 8'($urandom_range(0, 255));
        end else if (sel < 60) begin
            return 8'($urandom_range(0, 13));
        end else if (sel < 75) begin
            return 8'($urandom_range(240, 255));
        end else if (sel < 87) begin
            return 8'd0;
        end
        return 8'd255;
    endfunction

    // Stimulus: reset, directed pixels, then random pixels in bursts
    initial begin
        logic [23:0] directed [21];
        logic [7:0]  r, g, b;
        int          burst_left;
        int          gap;
        directed = '{
            {8'd0,   8'd0,   8'd0},      // black
            {8'd255, 8'd255, 8'd255},    // white
            {8'd255, 8'd0,   8'd0},
            {8'd0,   8'd255, 8'd0},
            {8'd0,   8'd0,   8'd255},
            {8'd10,  8'd10,  8'd10},     // top of the linear segment
            {8'd11,  8'd11,  8'd11},     // bottom of the power segment
            {8'd1,   8'd0,   8'd0},
            {8'd0,   8'd1,   8'd0},
            {8'd0,   8'd0,   8'd1},
            {8'd10,  8'd11,  8'd12},
            {8'd254, 8'd254, 8'd254},
            {8'd128, 8'd128, 8'd128},
            {8'd255, 8'd255, 8'd0},
            {8'd0,   8'd255, 8'd255},
            {8'd255, 8'd0,   8'd255},
            {8'd170, 8'd85,  8'd170},
            {8'd85,  8'd170, 8'd85},
            {8'd12,  8'd0,   8'd0},
            {8'd0,   8'd0,   8'd11},
            {8'd200, 8'd10,  8'd11}
        };
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            offer_pixel(directed[i][23:16], directed[i][15:8], directed[i][7:0]);
        end

        burst_left = $urandom_range(1, 40);
        for (int n = 0; n < NUM_RANDOM; n++) begin
            r = pick_channel();
            g = pick_channel();
            b = pick_channel();
            // some greys and pairs of equal channels
            case ($urandom_range(0, 9))
                0: begin
                    g = r;
                    b = r;
                end
                1: b = g;
                default: ;
            endcase
            offer_pixel(r, g, b);
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(60, 150)
                                                       : $urandom_range(1, 30);
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    i_s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        i_s_axis_tvalid <= 1'b0;

        // drain, then allow a few more cycles for stray results
        while (sb.pending_xyy.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending_xyy.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Receiver: checks each output transaction and stalls on its own pattern
    initial begin
        int unsigned mode;
        int          mode_left;
        int          hold_left;
        int          holds_done;
        int unsigned cyc;
        logic        rdy;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        holds_done = 0;
        cyc        = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_result(o_m_axis_tdata);
            end
            // long hold-off twice, so the pipeline fills and input stalls
            if (hold_left == 0 && holds_done < 2 &&
                sb.checked_count >= 400 + holds_done * 700) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(30, 250);
            end else begin
                mode_left--;
            end
            case (mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                2: rdy = (cyc % 5) != 0 && (cyc % 5) != 3;
                default: rdy = $urandom_range(0, 4) == 0;
            endcase
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end
            i_m_axis_tready <= rdy;
        end
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/sxyy_pkg.sv
hw/rtl/sxyy_linearize.sv
hw/rtl/sxyy_matrix.sv
hw/rtl/sxyy_divider.sv
hw/rtl/srgb_to_cie_xyy.sv
tb/tb_top.sv
